@@ rtl/core/fmt6_pkg.sv @@
// ----------------------------------------------------------------------------
// fmt6_pkg
// Types, constants and helpers for the IPv6 address text formatter.
// ----------------------------------------------------------------------------
package fmt6_pkg;

  localparam int unsigned GROUP_COUNT = 8;
  localparam int unsigned GROUP_W     = 16;
  localparam int unsigned GIDX_W      = $clog2(GROUP_COUNT);
  localparam int unsigned GLEN_W      = $clog2(GROUP_COUNT + 1);
  localparam int unsigned MIN_RUN     = 2;
  localparam int unsigned CHAR_W      = 7;

  localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  // 'a' minus ten
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h57;

  // Input transaction: one 128-bit address, byte 0 most significant
  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } fmt6_in_t;

  // Output transaction: one ASCII character
  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } fmt6_out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_START,
    ST_COLON,
    ST_DCOL,
    ST_DIGIT
  } fmt6_state_t;

  // Lowercase hex character for one nibble
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {3'b000, d};
    if (d < 4'd10) begin
      hex_char = CHAR_ZERO + dx;
    end else begin
      hex_char = CHAR_ALPHA + dx;
    end
  endfunction

  // Index of the leading nonzero nibble, zero for an all-zero group
  function automatic logic [1:0] lead_nib(input logic [GROUP_W-1:0] g);
    if (g[15:12] != 4'd0) begin
      lead_nib = 2'd3;
    end else if (g[11:8] != 4'd0) begin
      lead_nib = 2'd2;
    end else if (g[7:4] != 4'd0) begin
      lead_nib = 2'd1;
    end else begin
      lead_nib = 2'd0;
    end
  endfunction

endpackage

@@ rtl/core/format_ipv6_text_unit.sv @@
// ----------------------------------------------------------------------------
// format_ipv6_text_unit
// Canonical IPv6 text formatter: one address in, one ASCII character out
// per output transaction, zero run compressed to "::".
// ----------------------------------------------------------------------------
//
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+--------------------
//  in_     | input     | fmt6_in_t    | in_valid / in_ready
//  out_    | output    | fmt6_out_t   | out_valid / out_ready
//
// Ahead of its text an address is loaded, each of the eight groups gets one
// zero test in the shared compare, and a setup state runs; then the text
// follows, one character per output transaction, 2 to 39 characters.
// in_ready is high only while the sequencer is idle. A stall on out_ready
// holds the output register and freezes the character states of the
// sequencer. Reset clears the sequencer and the output valid flag.
module format_ipv6_text_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fmt6_pkg::fmt6_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fmt6_pkg::fmt6_out_t out_data
);
  import fmt6_pkg::*;

  fmt6_state_t          state_r, state_nxt;
  logic [127:0]         addr_r, addr_nxt;
  logic [GIDX_W-1:0]    grp_idx_r, grp_idx_nxt;
  logic [1:0]           nib_r, nib_nxt;
  logic                 dbl_r, dbl_nxt;
  logic [GLEN_W-1:0]    cur_len_r, cur_len_nxt;
  logic [GIDX_W-1:0]    cur_start_r, cur_start_nxt;
  logic [GLEN_W-1:0]    best_len_r, best_len_nxt;
  logic [GIDX_W-1:0]    best_start_r, best_start_nxt;
  logic                 out_valid_r, out_valid_nxt;
  fmt6_out_t            out_data_r, out_data_nxt;

  logic                 adv;
  logic                 run;
  logic [GROUP_W-1:0]   grp_cur;
  logic [GROUP_W-1:0]   grp_end;
  logic [GLEN_W-1:0]    grp_end_idx;
  logic [GLEN_W-1:0]    run_len;
  logic [GIDX_W-1:0]    grp_inc;

  // Select one 16-bit group, group 0 in the top bits
  function automatic logic [GROUP_W-1:0] grp_at(input logic [127:0] a,
                                                input logic [GIDX_W-1:0] idx);
    logic [GIDX_W-1:0] rev;
    rev    = GIDX_W'(GROUP_COUNT - 1) - idx;
    grp_at = a[{rev, 4'b0000} +: GROUP_W];
  endfunction

  assign adv         = !out_valid_r || out_ready;
  assign run         = (best_len_r >= GLEN_W'(MIN_RUN));
  assign grp_cur     = grp_at(addr_r, grp_idx_r);
  assign grp_end_idx = {1'b0, grp_idx_r} + best_len_r;
  assign grp_end     = grp_at(addr_r, grp_end_idx[GIDX_W-1:0]);
  assign run_len     = cur_len_r + GLEN_W'(1);
  assign grp_inc     = grp_idx_r + GIDX_W'(1);

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (grp_idx_r == GIDX_W'(GROUP_COUNT - 1)) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (run && (best_start_r == '0)) begin
          state_nxt = ST_COLON;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_COLON: begin
        if (adv) begin
          state_nxt = dbl_r ? ST_DCOL : ST_DIGIT;
        end
      end
      ST_DCOL: begin
        if (adv) begin
          if (grp_end_idx == GLEN_W'(GROUP_COUNT)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        if (adv && (nib_r == 2'd0)) begin
          if (grp_idx_r == GIDX_W'(GROUP_COUNT - 1)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_COLON;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output register
  always_comb begin
    addr_nxt       = addr_r;
    grp_idx_nxt    = grp_idx_r;
    nib_nxt        = nib_r;
    dbl_nxt        = dbl_r;
    cur_len_nxt    = cur_len_r;
    cur_start_nxt  = cur_start_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        // Load the address and clear the run search
        if (in_valid) begin
          addr_nxt       = {in_data.addr_high, in_data.addr_low};
          grp_idx_nxt    = '0;
          cur_len_nxt    = '0;
          cur_start_nxt  = '0;
          best_len_nxt   = '0;
          best_start_nxt = '0;
        end
      end
      ST_SCAN: begin
        // Test one group, extend or end the current zero run
        if (grp_cur == '0) begin
          cur_len_nxt = run_len;
          if (cur_len_r == '0) begin
            cur_start_nxt = grp_idx_r;
          end
          if (run_len > best_len_r) begin
            best_len_nxt   = run_len;
            best_start_nxt = (cur_len_r == '0) ? grp_idx_r : cur_start_r;
          end
        end else begin
          cur_len_nxt = '0;
        end
        grp_idx_nxt = grp_inc;
      end
      ST_START: begin
        // Group index has wrapped to zero
        dbl_nxt = run && (best_start_r == '0);
        nib_nxt = lead_nib(grp_cur);
      end
      ST_COLON: begin
        if (adv) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.text_char = CHAR_COLON;
          out_data_nxt.last_char = 1'b0;
          if (!dbl_r) begin
            nib_nxt = lead_nib(grp_cur);
          end
        end
      end
      ST_DCOL: begin
        // Second colon of the compressed run, then skip the run
        if (adv) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.text_char = CHAR_COLON;
          out_data_nxt.last_char = (grp_end_idx == GLEN_W'(GROUP_COUNT));
          grp_idx_nxt            = grp_end_idx[GIDX_W-1:0];
          nib_nxt                = lead_nib(grp_end);
        end
      end
      ST_DIGIT: begin
        if (adv) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.text_char = hex_char(grp_cur[{nib_r, 2'b00} +: 4]);
          out_data_nxt.last_char = (nib_r == 2'd0) &&
                                   (grp_idx_r == GIDX_W'(GROUP_COUNT - 1));
          if (nib_r == 2'd0) begin
            grp_idx_nxt = grp_inc;
            dbl_nxt     = run && (grp_inc == best_start_r);
          end else begin
            nib_nxt = nib_r - 2'd1;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r       <= addr_nxt;
    grp_idx_r    <= grp_idx_nxt;
    nib_r        <= nib_nxt;
    dbl_r        <= dbl_nxt;
    cur_len_r    <= cur_len_nxt;
    cur_start_r  <= cur_start_nxt;
    best_len_r   <= best_len_nxt;
    best_start_r <= best_start_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
